// File: design/sgso_pkg.sv
// Package for the smoothed gain sine oscillator: sequencer states, register
// indexes, reset values and the elaboration-time quarter-wave sine function.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package sgso_pkg;

	localparam int PHASE_BITS_DEF      = 32;
	localparam int SINE_TABLE_BITS_DEF = 10;

	localparam int TUNING_W = 32;
	localparam int GAIN_W   = 16;
	localparam int COEFF_W  = 16;
	localparam int Q30_W    = 31;   // unsigned Q1.30, holds 0 .. 2^30
	localparam int MUL_A_W  = 47;
	localparam int MUL_B_W  = 16;
	localparam int PROD_W   = MUL_A_W + MUL_B_W;

	localparam logic [GAIN_W-1:0]  GAIN_MAX_Q15 = 16'd32768;
	localparam logic [Q30_W-1:0]   Q30_ONE      = 31'h4000_0000;
	localparam logic [COEFF_W-1:0] COEFF_RESET  = 16'd131;
	localparam logic [COEFF_W-1:0] SCALE_RESET  = 16'd19661;
	localparam logic [15:0]        SAMPLE_MAX   = 16'd32767;

	// configuration register indexes
	typedef enum logic [0:0] {
		REG_SMOOTHING_COEFF = 1'b0,
		REG_OUTPUT_SCALE    = 1'b1
	} reg_index_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_STEP,
		ST_APPLY,
		ST_MAG1,
		ST_MAG2,
		ST_ROUND
	} state_t;

	// Quarter-wave entry k: sin(pi/2 * k / 2^tbits) in Q1.15, from a Q2.30
	// polynomial; evaluated only on constants.
	function automatic logic [15:0] qsine_entry(input int unsigned k, input int unsigned tbits);
		logic [63:0] one;
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] t;
		logic [63:0] sub;
		logic [63:0] v;
		one = 64'd1 << 30;
		x   = (64'd1686629713 * 64'(k)) >> tbits;
		x2  = (x * x) >> 30;
		t   = one;
		sub = ((x2 * t) >> 30) / 64'd156;
		t   = (sub >= one) ? 64'd0 : one - sub;
		sub = ((x2 * t) >> 30) / 64'd110;
		t   = (sub >= one) ? 64'd0 : one - sub;
		sub = ((x2 * t) >> 30) / 64'd72;
		t   = (sub >= one) ? 64'd0 : one - sub;
		sub = ((x2 * t) >> 30) / 64'd42;
		t   = (sub >= one) ? 64'd0 : one - sub;
		sub = ((x2 * t) >> 30) / 64'd20;
		t   = (sub >= one) ? 64'd0 : one - sub;
		sub = ((x2 * t) >> 30) / 64'd6;
		t   = (sub >= one) ? 64'd0 : one - sub;
		v   = (((x * t) >> 30) + 64'd16384) >> 15;
		if (v > 64'd32767) begin
			v = 64'd32767;
		end
		return v[15:0];
	endfunction

endpackage

`default_nettype wire

// File: design/smoothed_gain_sine_oscillator.sv
// Smoothed gain sine oscillator: phase accumulator, one-pole gain smoother
// and quarter-wave sine lookup, sequenced around one shared 47x16 multiplier.
// Per item: the gain step product, the gain and phase update, two magnitude
// products and output rounding (three passes through the shared multiplier);
// no new item is taken before the result is registered, which waits on stalls.
// Reset (arst_n low): phase and gain clear to zero, registers take defaults.
`timescale 1ns / 1ps
`default_nettype none

module smoothed_gain_sine_oscillator
	import sgso_pkg::*;
#(
	parameter int PHASE_BITS      = PHASE_BITS_DEF,
	parameter int SINE_TABLE_BITS = SINE_TABLE_BITS_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// configuration write port
	input  wire logic        cfg_we,
	input  wire logic [0:0]  cfg_index,
	input  wire logic [15:0] cfg_data,
	// input items
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [47:0] s_tdata,  // [31:0] tuning_word, [47:32] target_gain
	// result items
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [31:0]      m_tdata   // [15:0] sample, [31:16] gain_level
);

	localparam int TABLE_N = 1 << SINE_TABLE_BITS;
	localparam int ADDR_W  = SINE_TABLE_BITS + 1;

	// quarter-wave table, constant contents
	logic [15:0] sine_rom [TABLE_N+1];
	for (genvar k = 0; k <= TABLE_N; k++) begin : g_rom
		localparam logic [15:0] ENTRY = qsine_entry(k, SINE_TABLE_BITS);
		assign sine_rom[k] = ENTRY;
	end

	state_t state_q, state_d;

	logic [PHASE_BITS-1:0] phase_q;
	logic [Q30_W-1:0]      gain_q;
	logic [COEFF_W-1:0]    coeff_q;
	logic [COEFF_W-1:0]    scale_q;

	logic [PHASE_BITS-1:0] tune_q;
	logic [Q30_W-1:0]      diff_q;
	logic                  up_q;
	logic [15:0]           sine_q;
	logic                  neg_q;
	logic [PROD_W-1:0]     prod_q;
	logic [15:0]           sample_q;
	logic [15:0]           level_q;
	logic                  out_valid_q;

	// input unpacking
	logic [TUNING_W-1:0] in_tuning;
	logic [GAIN_W-1:0]   in_target;
	logic [GAIN_W-1:0]   target_sat;
	logic [Q30_W-1:0]    target_q30;
	logic [PHASE_BITS+TUNING_W-1:0] tune_wide;
	logic                in_accept;

	assign in_tuning  = s_tdata[31:0];
	assign in_target  = s_tdata[47:32];
	assign target_sat = (in_target > GAIN_MAX_Q15) ? GAIN_MAX_Q15 : in_target;
	assign target_q30 = {target_sat, 15'd0};
	assign tune_wide  = {{PHASE_BITS{1'b0}}, in_tuning};
	assign in_accept  = s_tvalid && s_tready;

	// table address from the current phase
	logic [1:0]                 quad;
	logic [SINE_TABLE_BITS-1:0] idx;
	logic [ADDR_W-1:0]          rom_addr;

	assign quad     = phase_q[PHASE_BITS-1 -: 2];
	assign idx      = phase_q[PHASE_BITS-3 -: SINE_TABLE_BITS];
	assign rom_addr = quad[0] ? (ADDR_W'(TABLE_N) - {1'b0, idx}) : {1'b0, idx};

	// shared multiplier
	logic [MUL_A_W-1:0] mul_a;
	logic [MUL_B_W-1:0] mul_b;
	logic [PROD_W-1:0]  mul_p;
	logic               prod_load;
	logic               out_free;
	logic               out_load;

	assign mul_p    = mul_a * mul_b;
	assign out_free = !out_valid_q || m_tready;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:  if (s_tvalid) state_d = ST_STEP;
			ST_STEP:  state_d = ST_APPLY;
			ST_APPLY: state_d = ST_MAG1;
			ST_MAG1:  state_d = ST_MAG2;
			ST_MAG2:  state_d = ST_ROUND;
			ST_ROUND: if (out_free) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	// state outputs
	always_comb begin
		s_tready  = 1'b0;
		mul_a     = '0;
		mul_b     = '0;
		prod_load = 1'b0;
		out_load  = 1'b0;
		case (state_q)
			ST_IDLE: s_tready = 1'b1;
			ST_STEP: begin
				mul_a     = MUL_A_W'(diff_q);
				mul_b     = coeff_q;
				prod_load = 1'b1;
			end
			ST_MAG1: begin
				mul_a     = MUL_A_W'(gain_q);
				mul_b     = sine_q;
				prod_load = 1'b1;
			end
			ST_MAG2: begin
				mul_a     = prod_q[MUL_A_W-1:0];
				mul_b     = scale_q;
				prod_load = 1'b1;
			end
			ST_ROUND: out_load = out_free;
			default: ;
		endcase
	end

	// rounding of the final product and gain readout
	logic [Q30_W-1:0]  step;
	logic [PROD_W-1:0] mag_sum;
	logic [16:0]       mag_full;
	logic [15:0]       mag;
	logic [Q30_W:0]    level_sum;

	assign step      = prod_q[16 +: Q30_W];
	assign mag_sum   = prod_q + (PROD_W'(1) << 45);
	assign mag_full  = mag_sum[62:46];
	assign mag       = (mag_full > 17'(SAMPLE_MAX)) ? SAMPLE_MAX : mag_full[15:0];
	assign level_sum = {1'b0, gain_q} + (Q30_W+1)'(16384);

	// architectural state and control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			phase_q     <= '0;
			gain_q      <= '0;
			coeff_q     <= COEFF_RESET;
			scale_q     <= SCALE_RESET;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				case (cfg_index)
					REG_SMOOTHING_COEFF: coeff_q <= cfg_data;
					REG_OUTPUT_SCALE:    scale_q <= cfg_data;
					default: ;
				endcase
			end
			if (state_q == ST_APPLY) begin
				gain_q  <= up_q ? gain_q + step : gain_q - step;
				phase_q <= phase_q + tune_q;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (in_accept) begin
			tune_q <= tune_wide[PHASE_BITS-1:0];
			up_q   <= target_q30 >= gain_q;
			diff_q <= (target_q30 >= gain_q) ? target_q30 - gain_q : gain_q - target_q30;
			sine_q <= sine_rom[rom_addr];
			neg_q  <= quad[1];
		end
		if (prod_load) begin
			prod_q <= mul_p;
		end
		if (out_load) begin
			sample_q <= neg_q ? 16'(16'd0 - mag) : mag;
			level_q  <= level_sum[30:15];
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {level_q, sample_q};

	// one item in flight: no accept right after an accept
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_accept |=> !s_tready)
		else $error("input accepted while an item is in flight");

	// smoothed gain never leaves [0, 1.0]
	a_gain_range: assert property (@(posedge clk) disable iff (!arst_n)
		gain_q <= Q30_ONE)
		else $error("smoothed gain above one");

	// phase advances only in the update step
	a_phase_hold: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != ST_APPLY |=> $stable(phase_q))
		else $error("phase changed outside update step");

	// a waiting result is never overwritten
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("pending result lost or changed");

endmodule

`default_nettype wire

// File: verif/sgso_checker.sv
// Checker for the smoothed gain sine oscillator: watches the config port and both
// streams, predicts every result and compares it field by field.
// Depends on sgso_pkg for default sizes and register indexes.
`timescale 1ns / 1ps

module sgso_checker
	import sgso_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [0:0]  cfg_index,
	input  logic [15:0] cfg_data,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [47:0] s_tdata,   // [31:0] tuning_word, [47:32] target_gain
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [31:0] m_tdata,   // [15:0] sample, [31:16] gain_level
	output int          fail_count,
	output int          pending_count
);

	localparam int PB    = PHASE_BITS_DEF;
	localparam int TB    = SINE_TABLE_BITS_DEF;
	localparam int TAB_N = 1 << TB;

	typedef struct packed {
		logic [15:0] gain_level;
		logic [15:0] sample;
	} osc_out_t;

	logic [15:0]   qsine [0:TAB_N];
	logic [PB-1:0] phase_acc;
	logic [63:0]   gain_q30;
	logic [15:0]   coeff_reg;
	logic [15:0]   scale_reg;
	osc_out_t      expected_out[$];
	int            result_num;

	// sin(pi/2 * k / TAB_N) through a nested Taylor polynomial in Q2.30, rounded to Q1.15
	function automatic logic [15:0] quarter_sine_entry(input int unsigned k);
		logic [63:0] divs [0:5];
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] t;
		logic [63:0] sub;
		logic [63:0] v;
		divs = '{64'd156, 64'd110, 64'd72, 64'd42, 64'd20, 64'd6};
		x    = (64'd1686629713 * 64'(k)) >> TB;
		x2   = (x * x) >> 30;
		t    = 64'd1 << 30;
		for (int i = 0; i < 6; i++) begin
			sub = ((x2 * t) >> 30) / divs[i];
			t   = (sub >= (64'd1 << 30)) ? 64'd0 : (64'd1 << 30) - sub;
		end
		v = (((x * t) >> 30) + 64'd16384) >> 15;
		if (v > 64'd32767) begin
			v = 64'd32767;
		end
		return v[15:0];
	endfunction

	initial begin
		for (int k = 0; k <= TAB_N; k++) begin
			qsine[k] = quarter_sine_entry(k);
		end
	end

	// slew the gain, look up the sine at the current phase, then advance the phase
	function automatic osc_out_t advance_oscillator(input logic [31:0] tuning,
			input logic [15:0] target);
		logic [63:0]   target_q30;
		logic [1:0]    quad;
		logic [TB-1:0] idx;
		logic [15:0]   sine_mag;
		logic [63:0]   mag;
		osc_out_t      res;
		target_q30 = (target > 16'd32768) ? (64'd32768 << 15) : (64'(target) << 15);
		if (target_q30 >= gain_q30) begin
			gain_q30 = gain_q30 + (((target_q30 - gain_q30) * 64'(coeff_reg)) >> 16);
		end else begin
			gain_q30 = gain_q30 - (((gain_q30 - target_q30) * 64'(coeff_reg)) >> 16);
		end
		quad     = phase_acc[PB-1 -: 2];
		idx      = phase_acc[PB-3 -: TB];
		sine_mag = quad[0] ? qsine[TAB_N - int'(idx)] : qsine[idx];
		mag      = 64'(sine_mag) * gain_q30 * 64'(scale_reg);
		mag      = (mag + (64'd1 << 45)) >> 46;
		if (mag > 64'd32767) begin
			mag = 64'd32767;
		end
		res.sample     = quad[1] ? 16'(-mag) : mag[15:0];
		res.gain_level = 16'((gain_q30 + 64'd16384) >> 15);
		phase_acc      = phase_acc + PB'(tuning);
		return res;
	endfunction

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("%0t ns: result %0d: %s got %0d expected %0d",
			$time, result_num, what, got, want);
		fail_count++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		osc_out_t want;
		osc_out_t got;
		if (!arst_n) begin
			phase_acc     = '0;
			gain_q30      = '0;
			coeff_reg     = 16'd131;
			scale_reg     = 16'd19661;
			expected_out.delete();
			pending_count = 0;
			result_num    = 0;
		end else begin
			if (cfg_we) begin
				case (reg_index_t'(cfg_index))
					REG_SMOOTHING_COEFF: coeff_reg = cfg_data;
					REG_OUTPUT_SCALE:    scale_reg = cfg_data;
					default: ;
				endcase
			end
			if (m_tvalid && m_tready) begin
				got = m_tdata;
				if (expected_out.size() == 0) begin
					report_mismatch("unexpected item, sample", int'($signed(got.sample)), 0);
				end else begin
					want = expected_out.pop_front();
					if (got.sample !== want.sample) begin
						report_mismatch("sample", int'($signed(got.sample)),
							int'($signed(want.sample)));
					end
					if (got.gain_level !== want.gain_level) begin
						report_mismatch("gain_level", int'(got.gain_level),
							int'(want.gain_level));
					end
				end
				result_num++;
			end
			if (s_tvalid && s_tready) begin
				expected_out.insert(expected_out.size(),
					advance_oscillator(s_tdata[31:0], s_tdata[47:32]));
			end
			pending_count = expected_out.size();
		end
	end

endmodule

// File: verif/tb_smoothed_gain_sine_oscillator.sv
// Testbench top for the smoothed gain sine oscillator: clock, reset, config
// writes, item stimulus with random gaps and stalls, and the verdict.
// Depends on sgso_pkg, smoothed_gain_sine_oscillator and sgso_checker.
`timescale 1ns / 1ps

module tb_smoothed_gain_sine_oscillator;
	import sgso_pkg::*;

	localparam int LONG_HOLD   = 300;
	localparam int CYCLE_LIMIT = 200000;
	localparam int NUM_PHASES  = 8;
	localparam int PHASE_ITEMS = 50;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [0:0]  cfg_index;
	logic [15:0] cfg_data;
	logic        s_tvalid;
	logic        s_tready;
	logic [47:0] s_tdata;   // [31:0] tuning_word, [47:32] target_gain
	logic        m_tvalid;
	logic        m_tready;
	logic [31:0] m_tdata;   // [15:0] sample, [31:16] gain_level
	int          fail_count;
	int          pending_count;
	bit          burst;
	bit          hold_req;
	int          cycle_count;

	smoothed_gain_sine_oscillator u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	sgso_checker u_chk (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.s_tvalid     (s_tvalid),
		.s_tready     (s_tready),
		.s_tdata      (s_tdata),
		.m_tvalid     (m_tvalid),
		.m_tready     (m_tready),
		.m_tdata      (m_tdata),
		.fail_count   (fail_count),
		.pending_count(pending_count)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	task automatic cfg_write(input reg_index_t idx, input logic [15:0] value);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(negedge clk);
		cfg_we    <= 1'b0;
	endtask

	// offer one item after a random gap and hold it until accepted
	task automatic send_item(input logic [31:0] tuning, input logic [15:0] target);
		int gap;
		gap = burst ? 0 : $urandom_range(0, 6);
		if (gap > 0) begin
			@(negedge clk);
			s_tvalid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tdata  <= {target, tuning};
		do @(posedge clk); while (!s_tready);
	endtask

	// drop valid and wait until every expected result has arrived
	task automatic drain;
		@(negedge clk);
		s_tvalid <= 1'b0;
		wait (pending_count == 0);
	endtask

	task automatic random_item;
		logic [31:0] tuning;
		logic [15:0] target;
		case ($urandom_range(0, 3))
			0:       tuning = $urandom_range(0, 1 << 24);
			1:       tuning = ($urandom_range(0, 3) << 30) | $urandom_range(0, 255);
			default: tuning = $urandom;
		endcase
		case ($urandom_range(0, 7))
			0:       target = 16'd0;
			1:       target = 16'd32768;
			2:       target = 16'($urandom);
			default: target = 16'($urandom_range(0, 32768));
		endcase
		send_item(tuning, target);
	endtask

	// result side: random stalls, one long hold when asked
	initial begin
		int gap;
		bit hold_done;
		hold_done = 1'b0;
		m_tready  = 1'b0;
		@(posedge arst_n);
		forever begin
			if (hold_req && !hold_done) begin
				gap       = LONG_HOLD;
				hold_done = 1'b1;
			end else begin
				gap = burst ? 0 : $urandom_range(0, 6);
			end
			if (gap > 0) begin
				@(negedge clk);
				m_tready <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
			@(negedge clk);
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
		end
	end

	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("tb_smoothed_gain_sine_oscillator NOT OK");
		$finish;
	end

	initial begin
		logic [15:0] coeff_set;
		logic [15:0] scale_set;
		arst_n    = 1'b0;
		cfg_we    = 1'b0;
		cfg_index = REG_SMOOTHING_COEFF;
		cfg_data  = '0;
		s_tvalid  = 1'b0;
		s_tdata   = '0;
		burst     = 1'b0;
		hold_req  = 1'b0;
		repeat (6) @(negedge clk);
		arst_n <= 1'b1;

		// full-scale settings: gain jumps almost to the target in one item
		cfg_write(REG_SMOOTHING_COEFF, 16'hFFFF);
		cfg_write(REG_OUTPUT_SCALE, 16'hFFFF);

		// walk the quadrant boundaries, saturated targets and the phase wrap
		send_item(32'h0000_0000, 16'd32768);
		send_item(32'h4000_0000, 16'hFFFF);
		send_item(32'h4000_0000, 16'd32769);
		send_item(32'h4000_0000, 16'd32768);
		send_item(32'h0040_0000, 16'd32768);
		send_item(32'hFFFF_FFFF, 16'd0);
		send_item(32'h0000_0001, 16'd16384);
		send_item(32'h3FC0_0000, 16'd32768);
		send_item(32'h2000_0000, 16'd1);
		send_item(32'h1FC0_0000, 16'd32767);
		send_item(32'h0000_0000, 16'd32768);
		send_item(32'h8000_0000, 16'd32768);
		send_item(32'hAAAA_AAAA, 16'hAAAA);
		send_item(32'h5555_5555, 16'h5555);
		send_item(32'hFFFF_FFFF, 16'hFFFF);
		send_item(32'h0000_0000, 16'd0);
		drain();

		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			case (ph)
				0: begin coeff_set = 16'd0;     scale_set = 16'hFFFF;  end
				1: begin coeff_set = 16'hFFFF;  scale_set = 16'd0;     end
				2: begin coeff_set = 16'd131;   scale_set = 16'd19661; end
				4: begin coeff_set = 16'd1;     scale_set = 16'hFFFF;  end
				5: begin coeff_set = 16'd8000;  scale_set = 16'd32768; end
				7: begin coeff_set = 16'hFFFF;  scale_set = 16'hFFFF;  end
				default: begin coeff_set = 16'($urandom); scale_set = 16'($urandom); end
			endcase
			cfg_write(REG_SMOOTHING_COEFF, coeff_set);
			cfg_write(REG_OUTPUT_SCALE, scale_set);
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				if (n % 10 == 0) begin
					burst = ($urandom_range(0, 3) == 0);
				end
				if (ph == 2 && n == 5) begin
					hold_req = 1'b1;
				end
				if (ph == 4 && n == 25) begin
					drain();
				end
				random_item();
			end
			drain();
		end

		repeat (20) @(posedge clk);
		if (fail_count == 0) begin
			$display("tb_smoothed_gain_sine_oscillator OK");
		end else begin
			$display("tb_smoothed_gain_sine_oscillator NOT OK");
		end
		$finish;
	end

endmodule
